// ===== hw/rtl/mexp_pkg.sv =====
// Package: sequencer states and register map for the modular exponentiation block.
package mexp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } mexp_state_t;

    // Register select: byte address bit 2 picks the 32-bit register slot.
    localparam logic REG_MODULUS = 1'b0;

    // Modulus value after reset, cut to the operand width at the top level.
    localparam logic [31:0] MODULUS_RESET = 32'd8192;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level: modular exponentiation by right-to-left square and multiply.
//
//  channel | signals                               | direction | payload
//  --------+---------------------------------------+-----------+---------------------------
//  req     | req_valid, req_ready                  | in        | base, exponent
//  rsp     | rsp_valid, rsp_ready                  | out       | power
//  apb     | psel, penable, pwrite, paddr, pwdata, | in/out    | modulus at byte address 0
//          | prdata, pready                        |           |
//
//  One transaction at a time. A single shift-add-reduce unit does every modular
//  multiplication, one multiplier bit per cycle. The base is first reduced through
//  the unit; then each exponent bit up to the highest set bit is dispatched to a
//  square, preceded by a multiply when the bit is set. After the last step the
//  sequencer passes through ST_FINISH and ST_IDLE before it accepts the next one.
//  rst_n is asynchronous, active low; the modulus resets to 8192.
//  The result sits in an output register, so req_ready returns while a result
//  is still waiting; a new result waits in ST_FINISH until that one is taken.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = 16,
    parameter int EXP_BITS     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // request
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [OPERAND_BITS-1:0] base,
    input  logic [EXP_BITS-1:0]     exponent,
    // response
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [OPERAND_BITS-1:0] power
);

    localparam int W     = OPERAND_BITS;
    localparam int CNT_W = $clog2(OPERAND_BITS);

    mexp_state_t          state_reg, state_next;

    logic [W-1:0]         modulus_reg;
    logic [EXP_BITS-1:0]  e_reg, e_next;
    logic [W-1:0]         acc_reg, acc_next;      // running result
    logic [W-1:0]         b_reg, b_next;          // running base power
    logic [W-1:0]         opa_reg, opa_next;      // multiplier, scanned MSB first
    logic [W-1:0]         opb_reg, opb_next;      // multiplicand, below modulus
    logic [W:0]           r_reg, r_next;          // partial remainder
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]         power_reg, power_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [W:0]           m_eff;
    logic [W+1:0]         t_sum, t_m1, t_m2, t_red;
    logic [W:0]           unit_res;
    logic                 unit_busy;
    logic                 unit_last;
    logic                 rsp_free;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(modulus_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET[W-1:0];
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS))
        begin
            modulus_reg <= pwdata[W-1:0];
        end
    end

    // Zero modulus stands for 2^W: arithmetic then wraps at operand width.
    assign m_eff = (modulus_reg == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_reg};

    // ------------------------------------------------------------------
    // Shared unit: r = 2r + (a_bit ? b : 0), then at most 2m taken off.
    // With r < m and b < m the sum stays below 3m.
    // ------------------------------------------------------------------
    assign t_sum = {r_reg, 1'b0} + (opa_reg[W-1] ? {2'b00, opb_reg} : '0);
    assign t_m1  = {1'b0, m_eff};
    assign t_m2  = {m_eff, 1'b0};

    always_comb
    begin
        priority if (t_sum >= t_m2)
        begin
            t_red = t_sum - t_m2;
        end
        else if (t_sum >= t_m1)
        begin
            t_red = t_sum - t_m1;
        end
        else
        begin
            t_red = t_sum;
        end
    end

    assign unit_res  = t_red[W:0];
    assign unit_busy = (state_reg == ST_REDUCE) || (state_reg == ST_MUL) ||
                       (state_reg == ST_SQR);
    assign unit_last = (cnt_reg == CNT_W'(W - 1));
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (unit_last)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                priority if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (unit_last)
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (unit_last)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath control and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready      = (state_reg == ST_IDLE);
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        power_next     = power_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (unit_busy)
        begin
            opa_next = {opa_reg[W-2:0], 1'b0};
            r_next   = unit_res;
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    // base mod m is base * 1 through the unit
                    e_next   = exponent;
                    acc_next = W'(1);
                    opa_next = base;
                    opb_next = W'(1);
                    r_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_REDUCE:
            begin
                if (unit_last)
                begin
                    b_next = unit_res[W-1:0];
                end
            end
            ST_STEP:
            begin
                if (e_reg != '0)
                begin
                    opa_next = e_reg[0] ? acc_reg : b_reg;
                    opb_next = b_reg;
                    r_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_MUL:
            begin
                if (unit_last)
                begin
                    acc_next = unit_res[W-1:0];
                    opa_next = b_reg;
                    opb_next = b_reg;
                    r_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_SQR:
            begin
                if (unit_last)
                begin
                    b_next = unit_res[W-1:0];
                    e_next = e_reg >> 1;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    power_next     = acc_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        r_reg     <= r_next;
        power_reg <= power_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign power     = power_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_REDUCE)
        else $error("accepted transaction did not start base reduction");

    a_mul_on_set_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> e_reg[0])
        else $error("multiply step on a clear exponent bit");

    a_unit_hands_on: assert property (@(posedge clk) disable iff (!rst_n)
        unit_busy && unit_last |=> state_reg != $past(state_reg))
        else $error("sequencer stayed in a unit state after its last bit");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && rsp_free |=> rsp_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not presented");
`endif

endmodule

// ===== bench/testbench.sv =====
// Testbench for the modular exponentiation block: scoreboard, stimulus and checking.
`timescale 1ns / 100ps

module testbench
    import mexp_pkg::*;
();

    // Longest run of cycles with no accepted transaction on any port before the run
    // is declared hung.
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 63;
    localparam int          PRESSURE_PHASE = 6;

    // Scoreboard: keeps its own copy of the modulus and predicts each power.
    class power_scoreboard;
        typedef struct
        {
            logic [15:0] b;
            logic [15:0] e;
            logic [15:0] p;
        } power_entry_t;

        logic [15:0]  modulus;
        power_entry_t expected_powers[$];
        int unsigned  requests;
        int unsigned  checked;
        int unsigned  errors;
        int unsigned  zero_exponents;
        int unsigned  modulus_writes;

        function new();
            modulus        = MODULUS_RESET[15:0];
            requests       = 0;
            checked        = 0;
            errors         = 0;
            zero_exponents = 0;
            modulus_writes = 0;
        endfunction

        // Register holds the low 16 bits; zero stands for 2^16.
        function void set_modulus(logic [31:0] value);
            modulus = value[15:0];
            modulus_writes++;
        endfunction

        // Right-to-left square and multiply at 64-bit width.
        function logic [15:0] modexp_power(logic [15:0] b_in, logic [15:0] e_in);
            longint unsigned m;
            longint unsigned sq;
            longint unsigned acc;
            m = 64'(modulus);
            if (m == 0)
                m = 64'd65536;
            sq  = 64'(b_in) % m;
            acc = 64'd1;
            for (int i = 0; i < 16; i++)
            begin
                if (e_in[i])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
            return acc[15:0];
        endfunction

        function void note_request(logic [15:0] b_in, logic [15:0] e_in);
            power_entry_t entry;
            entry.b = b_in;
            entry.e = e_in;
            entry.p = modexp_power(b_in, e_in);
            expected_powers.push_back(entry);
            requests++;
            if (e_in == 16'd0)
                zero_exponents++;
        endfunction

        function void check_power(logic [15:0] actual);
            power_entry_t entry;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected power, expected none, got %0d", $time, actual);
                errors++;
                return;
            end
            entry = expected_powers.pop_front();
            checked++;
            if (actual !== entry.p)
            begin
                $display("%0t: power mismatch for %0d^%0d mod %0d, expected %0d, got %0d",
                         $time, entry.b, entry.e, modulus, entry.p, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_ready;
    logic [15:0] base;
    logic [15:0] exponent;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [15:0] power;

    power_scoreboard sb = new();

    // Both sides skip their random gaps while this is set.
    bit          burst;
    // Raised by the stimulus to ask the response side for one more long hold-off;
    // the response side serves it while long_holds lags behind.
    int unsigned hold_requests;
    int unsigned long_holds;
    int unsigned idle_cycles = 0;

    modular_exponentiation dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .base      (base),
        .exponent  (exponent),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .power     (power)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: everything sampled at the rising edge, before the block's own updates land.
    // Results are checked before new requests are noted; a result always belongs to an
    // older transaction, so the order only matters for an unexpected result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_power(power);
            if (req_valid && req_ready)
                sb.note_request(base, exponent);
            if (psel && penable && pwrite && pready)
                sb.set_modulus(pwdata);
        end
    end

    // Watchdog counter: any accepted transaction on any port clears it.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("testbench failed");
        $finish;
    end

    // Response side: a random stall before each result, none in burst stretches,
    // and one long hold-off on request so the block backs up and stalls its input.
    initial
    begin
        int stall;
        rsp_ready     = 1'b0;
        long_holds    = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_requests > long_holds)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_holds++;
            end
            else
            begin
                stall = burst ? 0 : $urandom_range(0, 9);
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_modulus(input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODULUS, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request after a random gap; returns at the edge that accepted it,
    // leaving valid high so a back-to-back request needs no second assignment.
    task automatic send_request(input logic [15:0] b_in, input logic [15:0] e_in);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        base      <= b_in;
        exponent  <= e_in;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stop offering, then wait for every outstanding power and a short settle.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly full-width exponents, with short ones, single bits and the extremes mixed in.
    function automatic logic [15:0] pick_exponent();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            return 16'($urandom);
        else if (kind <= 7)
            return 16'($urandom_range(0, 31));
        else if (kind == 8)
            return 16'd1 << $urandom_range(0, 15);
        else
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // Bases include multiples of the modulus and its neighbours to hit the reduction.
    function automatic logic [15:0] pick_base(input logic [31:0] mod_value);
        int          kind;
        logic [16:0] m;
        kind = $urandom_range(0, 9);
        m    = (mod_value[15:0] == 16'd0) ? 17'h10000 : {1'b0, mod_value[15:0]};
        if (kind <= 6)
            return 16'($urandom);
        else if (kind == 7)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else if (kind == 8)
            return 16'(m * $urandom_range(0, 3));
        else
            return 16'(m - 17'd1 + $urandom_range(0, 2));
    endfunction

    initial
    begin
        logic [31:0] mod_choices[PHASES];
        logic [15:0] e_pick;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_valid     = 1'b0;
        base          = '0;
        exponent      = '0;
        burst         = 1'b0;
        hold_requests = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first under the reset modulus of 8192.
        send_request(16'd0,     16'd0);      // zero to the zero gives 1
        send_request(16'd0,     16'd1);
        send_request(16'hFFFF,  16'hFFFF);
        send_request(16'hFFFF,  16'd0);
        send_request(16'd1,     16'hFFFF);
        send_request(16'd2,     16'd12);     // 4096, just under the modulus
        send_request(16'd2,     16'd13);     // exactly the modulus, so 0
        send_request(16'd3,     16'd1);
        send_request(16'd8192,  16'd1);      // base reduced to 0 first
        send_request(16'd12345, 16'd2);
        drain_results();

        // Modulus of one: zero exponent still gives 1, anything else 0.
        write_modulus(32'd1);
        send_request(16'd5,     16'd0);
        send_request(16'd5,     16'd3);
        send_request(16'hFFFF,  16'hFFFF);
        drain_results();

        // Modulus written as zero: arithmetic wraps at 2^16.
        write_modulus(32'd0);
        send_request(16'hFFFF,  16'd2);
        send_request(16'd256,   16'd2);
        send_request(16'd3,     16'hFFFF);
        drain_results();

        write_modulus(32'd65535);
        send_request(16'hFFFF,  16'd7);
        send_request(16'hFFFE,  16'hFFFF);
        drain_results();

        // Upper data bits are dropped: this leaves a modulus of 7.
        write_modulus(32'hABCD_0007);
        send_request(16'd10,    16'd6);
        send_request(16'd7,     16'd0);

        // Random phases, each under its own modulus.
        mod_choices[0] = 32'd65521;
        mod_choices[1] = 32'd1;
        mod_choices[2] = 32'hFFFF_FFFF;
        mod_choices[3] = 32'd0;
        mod_choices[4] = 32'd2;
        mod_choices[5] = $urandom_range(3, 65534);
        mod_choices[6] = 32'd251;
        mod_choices[7] = $urandom;
        mod_choices[8] = 32'd3;
        mod_choices[9] = $urandom_range(256, 65535);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_modulus(mod_choices[ph]);
            burst = (ph % 4 == 2);
            // Long response hold: short exponents so the output register and the
            // sequencer fill quickly and the request side has to wait.
            if (ph == PRESSURE_PHASE)
                hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == PRESSURE_PHASE && i < 8)
                    e_pick = 16'($urandom_range(0, 3));
                else
                    e_pick = pick_exponent();
                send_request(pick_base(mod_choices[ph]), e_pick);
            end
        end

        burst = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected powers never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Checked %0d of %0d requests under %0d modulus writes, %0d zero exponents",
                 sb.checked, sb.requests, sb.modulus_writes, sb.zero_exponents);
        $display("Covered modulus one, zero and all-ones, gapless bursts and %0d long hold-off",
                 long_holds);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
